@@ src/ptp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_pkg
// shared widths, beat types and sideband structs of the tangent plane mapper
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int unsigned CW         = 32;   // coordinate width
    localparam int unsigned TRIG_BITS  = 28;   // fraction bits of sin and cos
    localparam int unsigned D_W        = CW + 1;
    localparam int unsigned SQ_STAGES  = 32;
    localparam int unsigned DIV_STAGES = 30;
    localparam int unsigned NUM_W      = 33;
    localparam int unsigned ANG_W      = 31;
    localparam int unsigned A_W        = 37;
    localparam int unsigned RV_W       = 41;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned ADDR_W     = 3;

    localparam logic [0:0]       REG_FLUSH_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET           = 16'd1;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] map_x;
        logic signed [CW-1:0] map_y;
        logic                 zero_normal;
    } out_item_t;

    typedef struct packed {
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
        logic                  nx_neg;
        logic                  ny_neg;
        logic                  nz_neg;
        logic                  xz_zero;
        logic                  zero_all;
    } side_t;

    typedef struct packed {
        side_t         side;
        logic [CW-1:0] num_x;
        logic [CW-1:0] num_z;
        logic [CW-1:0] num_y;
    } sq_tag_t;

    typedef struct packed {
        logic signed [D_W-1:0]   y1;
        logic signed [ANG_W-1:0] cx;
        logic signed [ANG_W-1:0] sx;
        logic                    zero_all;
    } ytag_t;

    typedef struct packed {
        logic signed [RV_W-1:0] x1;
        logic                   zero_all;
    } xtag_t;

endpackage
`default_nettype wire

@@ src/ptp_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_sqrt
// three-lane integer square root, one root bit per pipeline stage
// ----------------------------------------------------------------------------
module ptp_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [63:0]                rad [3],
    input  wire ptp_pkg::sq_tag_t           tag_in,
    output logic                            out_valid,
    output logic [ptp_pkg::NUM_W-1:0]       root [3],
    output ptp_pkg::sq_tag_t                tag_out
);

    localparam int unsigned N = ptp_pkg::SQ_STAGES;

    logic             v_reg   [N];
    logic [63:0]      n_reg   [N][3];
    logic [63:0]      r_reg   [N][3];
    logic [63:0]      n_next  [N][3];
    logic [63:0]      r_next  [N][3];
    ptp_pkg::sq_tag_t tag_reg [N];

    always_comb
    begin
        logic [63:0] n_cur;
        logic [63:0] r_cur;
        logic [63:0] bitv;
        logic [64:0] trial;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                n_cur = (k == 0) ? rad[l] : n_reg[(k == 0) ? 0 : k - 1][l];
                r_cur = (k == 0) ? 64'd0 : r_reg[(k == 0) ? 0 : k - 1][l];
                bitv  = 64'd1 << (62 - 2 * k);
                trial = {1'b0, r_cur} + {1'b0, bitv};
                if ({1'b0, n_cur} >= trial)
                begin
                    n_next[k][l] = n_cur - trial[63:0];
                    r_next[k][l] = (r_cur >> 1) + bitv;
                end
                else
                begin
                    n_next[k][l] = n_cur;
                    r_next[k][l] = r_cur >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        for (int k = 1; k < N; k++)
            tag_reg[k] <= tag_reg[k-1];
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                n_reg[k][l] <= n_next[k][l];
                r_reg[k][l] <= r_next[k][l];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign tag_out   = tag_reg[N-1];
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            root[l] = r_reg[N-1][l][ptp_pkg::NUM_W-1:0];
    end

endmodule
`default_nettype wire

@@ src/ptp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_div
// four-lane rounded restoring divider, (num << 28 + den/2) / den
// ----------------------------------------------------------------------------
module ptp_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [ptp_pkg::NUM_W-1:0]      num [4],
    input  wire logic [ptp_pkg::NUM_W-1:0]      den [4],
    input  wire ptp_pkg::side_t                 tag_in,
    output logic                                out_valid,
    output logic [ptp_pkg::DIV_STAGES-1:0]      quo [4],
    output ptp_pkg::side_t                      tag_out
);

    localparam int unsigned N  = ptp_pkg::DIV_STAGES;
    localparam int unsigned NW = ptp_pkg::NUM_W;
    localparam int unsigned TB = ptp_pkg::TRIG_BITS;

    // prep stage forms the rounded dividend
    logic                   pv_reg;
    logic [63:0]            prem_reg [4];
    logic [NW-1:0]          pden_reg [4];
    ptp_pkg::side_t         ptag_reg;

    logic                   v_reg    [N];
    logic [63:0]            rem_reg  [N][4];
    logic [NW-1:0]          den_reg  [N][4];
    logic [N-1:0]           q_reg    [N][4];
    logic [63:0]            rem_next [N][4];
    logic [N-1:0]           q_next   [N][4];
    ptp_pkg::side_t         tag_reg  [N];

    always_comb
    begin
        logic [63:0]   rem_cur;
        logic [NW-1:0] den_cur;
        logic [N-1:0]  q_cur;
        logic [63:0]   dd;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_cur = (k == 0) ? prem_reg[l] : rem_reg[(k == 0) ? 0 : k - 1][l];
                den_cur = (k == 0) ? pden_reg[l] : den_reg[(k == 0) ? 0 : k - 1][l];
                q_cur   = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k - 1][l];
                dd      = 64'(den_cur) << (N - 1 - k);
                if (rem_cur >= dd)
                begin
                    rem_next[k][l] = rem_cur - dd;
                    q_next[k][l]   = q_cur | (N'(1) << (N - 1 - k));
                end
                else
                begin
                    rem_next[k][l] = rem_cur;
                    q_next[k][l]   = q_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            for (int k = 0; k < N; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            pv_reg   <= in_valid;
            v_reg[0] <= pv_reg;
            for (int k = 1; k < N; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ptag_reg   <= tag_in;
        tag_reg[0] <= ptag_reg;
        for (int k = 1; k < N; k++)
            tag_reg[k] <= tag_reg[k-1];
        for (int l = 0; l < 4; l++)
        begin
            prem_reg[l] <= {(64 - NW - TB)'(0), num[l], TB'(0)}
                           + 64'(den[l][NW-1:1]);
            pden_reg[l] <= den[l];
        end
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[k][l] <= rem_next[k][l];
                q_reg[k][l]   <= q_next[k][l];
                den_reg[k][l] <= (k == 0) ? pden_reg[l] : den_reg[(k == 0) ? 0 : k - 1][l];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign tag_out   = tag_reg[N-1];
    always_comb
    begin
        for (int l = 0; l < 4; l++)
            quo[l] = q_reg[N-1][l];
    end

endmodule
`default_nettype wire

@@ src/ptp_rot.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_rot
// plane rotation of a pair, rounded shift by the trig fraction and flush
// ----------------------------------------------------------------------------
module ptp_rot #(
    parameter int unsigned TAG_W = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic signed [ptp_pkg::A_W-1:0]     a,
    input  wire logic signed [ptp_pkg::A_W-1:0]     b,
    input  wire logic signed [ptp_pkg::ANG_W-1:0]   c,
    input  wire logic signed [ptp_pkg::ANG_W-1:0]   s,
    input  wire logic [ptp_pkg::THR_W-1:0]          thr,
    input  wire logic [TAG_W-1:0]                   tag_in,
    output logic                                    out_valid,
    output logic signed [ptp_pkg::RV_W-1:0]         out_a,
    output logic signed [ptp_pkg::RV_W-1:0]         out_b,
    output logic [TAG_W-1:0]                        tag_out
);

    localparam int unsigned PW = ptp_pkg::A_W + ptp_pkg::ANG_W;
    localparam int unsigned SW = PW + 1;
    localparam int unsigned TB = ptp_pkg::TRIG_BITS;
    localparam int unsigned QW = SW + 1 - TB;
    localparam int unsigned RW = ptp_pkg::RV_W;

    logic [4:0]             v_reg;
    logic [TAG_W-1:0]       tag_reg [5];
    logic signed [PW-1:0]   pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [SW-1:0]   sa_reg, sb_reg;
    logic [SW-1:0]          ma_reg, mb_reg;
    logic [1:0]             n1_reg, n2_reg;
    logic [QW-1:0]          qa_reg, qb_reg;
    logic signed [RW-1:0]   oa_reg, ob_reg;
    logic [SW:0]            ra_next, rb_next;

    assign ra_next = {1'b0, ma_reg} + ((SW + 1)'(1) << (TB - 1));
    assign rb_next = {1'b0, mb_reg} + ((SW + 1)'(1) << (TB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= tag_in;
        for (int k = 1; k < 5; k++)
            tag_reg[k] <= tag_reg[k-1];
        // products
        pa_reg <= PW'(c) * PW'(a);
        pb_reg <= PW'(s) * PW'(b);
        pc_reg <= PW'(c) * PW'(b);
        pd_reg <= PW'(s) * PW'(a);
        // sums
        sa_reg <= SW'(pa_reg) + SW'(pb_reg);
        sb_reg <= SW'(pc_reg) - SW'(pd_reg);
        // magnitudes
        ma_reg <= sa_reg[SW-1] ? $unsigned(-sa_reg) : $unsigned(sa_reg);
        mb_reg <= sb_reg[SW-1] ? $unsigned(-sb_reg) : $unsigned(sb_reg);
        n1_reg <= {sb_reg[SW-1], sa_reg[SW-1]};
        // round to nearest, ties away from zero
        qa_reg <= ra_next[SW:TB];
        qb_reg <= rb_next[SW:TB];
        n2_reg <= n1_reg;
        // flush small magnitudes
        if (qa_reg < QW'(thr))
            oa_reg <= '0;
        else
            oa_reg <= n2_reg[0] ? -RW'(qa_reg) : RW'(qa_reg);
        if (qb_reg < QW'(thr))
            ob_reg <= '0;
        else
            ob_reg <= n2_reg[1] ? -RW'(qb_reg) : RW'(qb_reg);
    end

    assign out_valid = v_reg[4];
    assign out_a     = oa_reg;
    assign out_b     = ob_reg;
    assign tag_out   = tag_reg[4];

endmodule
`default_nettype wire

@@ src/point_to_tangent_plane_map_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_to_tangent_plane_map_top
// maps a 3d point into the tangent plane of a normal through a center
// ----------------------------------------------------------------------------
// usage
//   input beat: raise start with item for one cycle; taken when busy is low.
//   busy is always low: a new beat can be taken every cycle.
//   result beat: done is high for one cycle with result; there is no
//   backpressure, the receiver takes every result as it comes.
//   throughput one beat per cycle. the latency is set by the two
//   bit-per-stage units: 32 square root stages and 31 divider stages,
//   plus 5 front stages, 1 angle stage, two 5-stage rotations and the
//   output register.
//   apb port: one register, flush_threshold at byte address 0. the
//   user writes it only while the pipeline is empty; the block itself
//   does not enforce this. pready is always high.
//   reset: pipeline valid bits clear, flush_threshold returns to 1.
// ----------------------------------------------------------------------------
module point_to_tangent_plane_map_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire ptp_pkg::in_item_t              item,
    output logic                                done,
    output ptp_pkg::out_item_t                  result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptp_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int unsigned CW    = ptp_pkg::CW;
    localparam int unsigned D_W   = ptp_pkg::D_W;
    localparam int unsigned A_W   = ptp_pkg::A_W;
    localparam int unsigned RV_W  = ptp_pkg::RV_W;
    localparam int unsigned ANG_W = ptp_pkg::ANG_W;
    localparam int unsigned NW    = ptp_pkg::NUM_W;
    localparam int unsigned TB    = ptp_pkg::TRIG_BITS;
    localparam int unsigned QN    = ptp_pkg::DIV_STAGES;
    localparam int unsigned LAT   = 5 + ptp_pkg::SQ_STAGES + ptp_pkg::DIV_STAGES + 1
                                    + 1 + 5 + 5 + 1;
    localparam logic signed [RV_W-1:0] SAT_HI = RV_W'(64'(2) ** (CW - 1) - 1);
    localparam logic signed [RV_W-1:0] SAT_LO = -SAT_HI - RV_W'(1);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [ptp_pkg::THR_W-1:0] thr_reg;
    logic                      cfg_hit;

    assign cfg_hit = (paddr[ptp_pkg::ADDR_W-1:2] == ptp_pkg::REG_FLUSH_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? 32'(thr_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= ptp_pkg::THR_RESET;
        else if (psel && penable && pwrite && cfg_hit)
            thr_reg <= pwdata[ptp_pkg::THR_W-1:0];
    end

    assign busy = 1'b0;

    function automatic logic [CW-1:0] mag32(input logic signed [CW-1:0] v);
        return v[CW-1] ? (~v + CW'(1)) : v;
    endfunction

    // shift that brings a nonzero largest magnitude into [2^30, 2^31]
    function automatic logic [4:0] norm_up(input logic [CW-1:0] mx);
        int msb;
        msb = 0;
        for (int i = 0; i < CW; i++)
            if (mx[i])
                msb = i;
        if (msb >= 30)
            return 5'd0;
        return 5'(30 - msb);
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [RV_W-1:0] v);
        if (v > SAT_HI)
            return CW'(SAT_HI);
        if (v < SAT_LO)
            return CW'(SAT_LO);
        return CW'(v);
    endfunction

    // ------------------------------------------------------------------
    // stage 1: differences, magnitudes, zero tests
    // ------------------------------------------------------------------
    logic            acc;
    logic            v1_reg;
    ptp_pkg::side_t  side1_reg;
    logic [CW-1:0]   m1_reg [3];

    assign acc = start && !busy;

    always_ff @(posedge clk)
    begin
        side1_reg.d0       <= D_W'(item.point_x) - D_W'(item.center_x);
        side1_reg.d1       <= D_W'(item.point_y) - D_W'(item.center_y);
        side1_reg.d2       <= D_W'(item.point_z) - D_W'(item.center_z);
        side1_reg.nx_neg   <= item.normal_x[CW-1];
        side1_reg.ny_neg   <= item.normal_y[CW-1];
        side1_reg.nz_neg   <= item.normal_z[CW-1];
        side1_reg.xz_zero  <= (item.normal_x == '0) && (item.normal_z == '0);
        side1_reg.zero_all <= (item.normal_x == '0) && (item.normal_y == '0)
                              && (item.normal_z == '0);
        m1_reg[0]          <= mag32(item.normal_x);
        m1_reg[1]          <= mag32(item.normal_y);
        m1_reg[2]          <= mag32(item.normal_z);
    end

    // ------------------------------------------------------------------
    // stage 2: normalizing shifts, y difference flush
    // ------------------------------------------------------------------
    logic            v2_reg;
    ptp_pkg::side_t  side2_reg;
    ptp_pkg::side_t  side1_f;
    logic [CW-1:0]   m2_reg [3];
    logic [4:0]      upp_reg, upt_reg;
    logic [CW-1:0]   mxp, mxt;
    logic [D_W-1:0]  d1_mag;

    assign mxp    = (m1_reg[0] > m1_reg[2]) ? m1_reg[0] : m1_reg[2];
    assign mxt    = (mxp > m1_reg[1]) ? mxp : m1_reg[1];
    assign d1_mag = side1_reg.d1[D_W-1] ? (~side1_reg.d1 + D_W'(1)) : side1_reg.d1;

    always_comb
    begin
        side1_f = side1_reg;
        if (d1_mag < D_W'(thr_reg))
            side1_f.d1 = '0;
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side1_f;
        m2_reg    <= m1_reg;
        upp_reg   <= norm_up(mxp);
        upt_reg   <= norm_up(mxt);
    end

    // ------------------------------------------------------------------
    // stage 3: scaled magnitudes, pair (x,z) and triple (x,y,z)
    // ------------------------------------------------------------------
    logic            v3_reg;
    ptp_pkg::side_t  side3_reg;
    logic [CW-1:0]   px3_reg, pz3_reg, tx3_reg, ty3_reg, tz3_reg;

    always_ff @(posedge clk)
    begin
        side3_reg <= side2_reg;
        px3_reg   <= m2_reg[0] << upp_reg;
        pz3_reg   <= m2_reg[2] << upp_reg;
        tx3_reg   <= m2_reg[0] << upt_reg;
        ty3_reg   <= m2_reg[1] << upt_reg;
        tz3_reg   <= m2_reg[2] << upt_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: squares
    // ------------------------------------------------------------------
    logic             v4_reg;
    ptp_pkg::sq_tag_t tag4_reg;
    logic [63:0]      spx_reg, spz_reg, stx_reg, sty_reg, stz_reg;

    always_ff @(posedge clk)
    begin
        tag4_reg.side  <= side3_reg;
        tag4_reg.num_x <= px3_reg;
        tag4_reg.num_z <= pz3_reg;
        tag4_reg.num_y <= ty3_reg;
        spx_reg        <= 64'(px3_reg) * 64'(px3_reg);
        spz_reg        <= 64'(pz3_reg) * 64'(pz3_reg);
        stx_reg        <= 64'(tx3_reg) * 64'(tx3_reg);
        sty_reg        <= 64'(ty3_reg) * 64'(ty3_reg);
        stz_reg        <= 64'(tz3_reg) * 64'(tz3_reg);
    end

    // ------------------------------------------------------------------
    // stage 5: sums of squares
    // ------------------------------------------------------------------
    logic             v5_reg;
    ptp_pkg::sq_tag_t tag5_reg;
    logic [63:0]      rad5_reg [3];

    always_ff @(posedge clk)
    begin
        tag5_reg    <= tag4_reg;
        rad5_reg[0] <= spx_reg + spz_reg;
        rad5_reg[1] <= stx_reg + stz_reg;
        rad5_reg[2] <= stx_reg + sty_reg + stz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // roots: r1 of the pair, r1 and r2 of the triple
    // ------------------------------------------------------------------
    logic             sq_valid;
    logic [NW-1:0]    root [3];
    ptp_pkg::sq_tag_t sq_tag;

    ptp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .rad       (rad5_reg),
        .tag_in    (tag5_reg),
        .out_valid (sq_valid),
        .root      (root),
        .tag_out   (sq_tag)
    );

    // ------------------------------------------------------------------
    // quotients: cos y, sin y, cos x, sin x magnitudes
    // ------------------------------------------------------------------
    logic            dv_valid;
    logic [NW-1:0]   dnum [4];
    logic [NW-1:0]   dden [4];
    logic [QN-1:0]   quo [4];
    ptp_pkg::side_t  dv_side;

    assign dnum[0] = NW'(sq_tag.num_z);
    assign dden[0] = root[0];
    assign dnum[1] = NW'(sq_tag.num_x);
    assign dden[1] = root[0];
    assign dnum[2] = root[1];
    assign dden[2] = root[2];
    assign dnum[3] = NW'(sq_tag.num_y);
    assign dden[3] = root[2];

    ptp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .num       (dnum),
        .den       (dden),
        .tag_in    (sq_tag.side),
        .out_valid (dv_valid),
        .quo       (quo),
        .tag_out   (dv_side)
    );

    // ------------------------------------------------------------------
    // angle stage: apply signs, default y rotation for a normal along y
    // ------------------------------------------------------------------
    logic                     va_reg;
    ptp_pkg::side_t           sidea_reg;
    logic signed [ANG_W-1:0]  cy_reg, sy_reg, cx_reg, sx_reg;
    logic signed [ANG_W-1:0]  q_s [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            q_s[l] = $signed(ANG_W'(quo[l]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        sidea_reg <= dv_side;
        if (dv_side.xz_zero)
        begin
            cy_reg <= ANG_W'(1) << TB;
            sy_reg <= '0;
        end
        else
        begin
            cy_reg <= dv_side.nz_neg ? -q_s[0] : q_s[0];
            sy_reg <= dv_side.nx_neg ? q_s[1] : -q_s[1];
        end
        cx_reg <= q_s[2];
        sx_reg <= dv_side.ny_neg ? -q_s[3] : q_s[3];
    end

    // ------------------------------------------------------------------
    // rotation about y: x1 and z1, flushed
    // ------------------------------------------------------------------
    ptp_pkg::ytag_t          ytag_in, ytag_out;
    logic                    yv;
    logic signed [RV_W-1:0]  x1, z1;

    assign ytag_in.y1       = sidea_reg.d1;
    assign ytag_in.cx       = cx_reg;
    assign ytag_in.sx       = sx_reg;
    assign ytag_in.zero_all = sidea_reg.zero_all;

    ptp_rot #(.TAG_W($bits(ptp_pkg::ytag_t))) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (va_reg),
        .a         (A_W'(sidea_reg.d0)),
        .b         (A_W'(sidea_reg.d2)),
        .c         (cy_reg),
        .s         (sy_reg),
        .thr       (thr_reg),
        .tag_in    (ytag_in),
        .out_valid (yv),
        .out_a     (x1),
        .out_b     (z1),
        .tag_out   (ytag_out)
    );

    // ------------------------------------------------------------------
    // rotation about x: y2 = cx*y1 - sx*z1, flushed; x passes along
    // ------------------------------------------------------------------
    ptp_pkg::xtag_t          xtag_in, xtag_out;
    logic                    xv;
    logic signed [RV_W-1:0]  y2;

    assign xtag_in.x1       = x1;
    assign xtag_in.zero_all = ytag_out.zero_all;

    ptp_rot #(.TAG_W($bits(ptp_pkg::xtag_t))) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yv),
        .a         (A_W'(z1)),
        .b         (A_W'(ytag_out.y1)),
        .c         (ytag_out.cx),
        .s         (ytag_out.sx),
        .thr       (thr_reg),
        .tag_in    (xtag_in),
        .out_valid (xv),
        .out_a     (),
        .out_b     (y2),
        .tag_out   (xtag_out)
    );

    // ------------------------------------------------------------------
    // output register: saturation, zero normal override
    // ------------------------------------------------------------------
    logic               done_reg;
    ptp_pkg::out_item_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= xv;
    end

    always_ff @(posedge clk)
    begin
        if (xtag_out.zero_all)
        begin
            out_reg.map_x       <= '0;
            out_reg.map_y       <= '0;
            out_reg.zero_normal <= 1'b1;
        end
        else
        begin
            out_reg.map_x       <= sat(xtag_out.x1);
            out_reg.map_y       <= sat(y2);
            out_reg.zero_normal <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_normal |-> result.map_x == '0 && result.map_y == '0)
        else $error("zero normal beat with nonzero outputs");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> v1_reg)
        else $error("accepted beat did not enter the pipeline");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc, LAT))
        else $error("result beat without a beat accepted at the pipeline latency");

endmodule
`default_nettype wire
